>>> design/rdtg_pkg.sv
package rdtg_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int NUM_COEFFS_DEF = 20;

    localparam int DIM_W    = 13;
    localparam int PIX_W    = 12;
    localparam int WORD_W   = 32;
    localparam int CIDX_W   = 5;
    localparam int DEPTH_W  = 25;
    localparam int PIDX_W   = 24;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 56;

    localparam int IN_X_LSB    = 0;
    localparam int IN_Y_LSB    = 12;
    localparam int IN_T_LSB    = 24;
    localparam int IN_FIN_BIT  = 56;
    localparam int IN_CIDX_LSB = 57;
    localparam int IN_CVAL_LSB = 62;

    localparam int FRAC_QW    = 28;
    localparam int NORM_QW    = 17;
    localparam int DEPTH_QW   = 24;
    localparam int SUMSQ_W    = 64;
    localparam int ISQ_STAGES = SUMSQ_W / 2;
    localparam int ZW_W       = 51;

    localparam logic [DEPTH_W-1:0] DEPTH_ONE = 25'h100_0000;

    localparam int COEFF_EYE   = 0;
    localparam int COEFF_DIR00 = 3;
    localparam int COEFF_DU    = 6;
    localparam int COEFF_DV    = 9;
    localparam int COEFF_ZROW  = 12;
    localparam int COEFF_WROW  = 16;

    localparam logic FUNC_LOAD = 1'b1;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_REGION_MIN_X,
        REG_REGION_MAX_X,
        REG_REGION_MIN_Y,
        REG_REGION_MAX_Y
    } reg_index_t;

    typedef struct packed {
        logic                     fin;
        logic signed [WORD_W-1:0] t;
        logic [PIDX_W-1:0]        pidx;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        return (v + 64'sd32768) >>> 16;
    endfunction

endpackage

>>> design/rdtg_udiv.sv
module rdtg_udiv #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 13,
    parameter int Q_W   = 28
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot,
    output logic [DEN_W-1:0] rem,
    output logic [DEN_W-1:0] den_out
);

    localparam int RW = DEN_W + Q_W;

    logic [RW-1:0]    rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];

    genvar s;
    generate
        for (s = 0; s < Q_W; s++)
        begin : g_stage
            localparam int K = Q_W - 1 - s;
            logic [RW-1:0]    rem_in;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   q_in;
            logic [RW-1:0]    sub;
            logic             take;
            logic [RW-1:0]    rem_next;
            logic [Q_W-1:0]   q_next;

            if (s == 0)
            begin : g_first
                assign rem_in = RW'(num);
                assign den_in = den;
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign q_in   = q_reg[s-1];
            end

            assign sub      = RW'(den_in) << K;
            assign take     = rem_in >= sub;
            assign rem_next = take ? (rem_in - sub) : rem_in;
            assign q_next   = take ? (q_in | (Q_W'(1) << K)) : q_in;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_in;
                    q_reg[s]   <= q_next;
                end
            end
        end
    endgenerate

    assign quot    = q_reg[Q_W-1];
    assign rem     = rem_reg[Q_W-1][DEN_W-1:0];
    assign den_out = den_reg[Q_W-1];

endmodule

>>> design/rdtg_isqrt.sv
module rdtg_isqrt #(
    parameter int IN_W = 64
) (
    input  logic              clk,
    input  logic              en,
    input  logic [IN_W-1:0]   v,
    output logic [IN_W/2-1:0] root
);

    localparam int STAGES = IN_W / 2;

    logic [IN_W-1:0] rem_reg  [STAGES];
    logic [IN_W-1:0] root_reg [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            localparam logic [IN_W-1:0] BIT = IN_W'(1) << (IN_W - 2 - 2 * s);
            logic [IN_W-1:0] rem_in;
            logic [IN_W-1:0] root_in;
            logic [IN_W-1:0] trial;
            logic            take;
            logic [IN_W-1:0] rem_next;
            logic [IN_W-1:0] root_next;

            if (s == 0)
            begin : g_first
                assign rem_in  = v;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
            end

            assign trial     = root_in + BIT;
            assign take      = rem_in >= trial;
            assign rem_next  = take ? (rem_in - trial) : rem_in;
            assign root_next = take ? ((root_in >> 1) + BIT) : (root_in >> 1);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[STAGES-1][IN_W/2-1:0];

endmodule

>>> design/ray_distance_to_gl_depth_core.sv
// A pixel transaction accepted on the input gives its result on the output after passing
// through the pipelined dividers and the square root, which all stall with the output.
// Throughput: one pixel per cycle while the output is not stalled; a coefficient load is
// taken only once all pixels in flight have been delivered.
// Reset clears the valid bits and the in-flight count and sets the configuration registers
// to their defaults; the coefficient table is undefined until loaded.
module ray_distance_to_gl_depth_core #(
    parameter int MAX_WIDTH  = rdtg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rdtg_pkg::MAX_HEIGHT_DEF,
    parameter int NUM_COEFFS = rdtg_pkg::NUM_COEFFS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rdtg_pkg::APB_AW-1:0]     paddr,
    input  logic [rdtg_pkg::APB_DW-1:0]     pwdata,
    output logic [rdtg_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pixel_x, pixel_y, ray_distance, distance_finite, coeff_index, coeff_value
    input  logic [rdtg_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [rdtg_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // depth, pixel_index
    output logic [rdtg_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import rdtg_pkg::*;

    localparam int IDX_W  = $clog2(NUM_COEFFS);
    localparam int L_A    = 0;
    localparam int L_FRAC = L_A + FRAC_QW;
    localparam int L_B1   = L_FRAC + 1;
    localparam int L_B2   = L_B1 + 1;
    localparam int L_C1   = L_B2 + 1;
    localparam int L_C2   = L_C1 + 1;
    localparam int L_D1   = L_C2 + 1;
    localparam int L_D2   = L_D1 + 1;
    localparam int L_SQ   = L_D2 + ISQ_STAGES;
    localparam int L_E    = L_SQ + 1;
    localparam int L_N    = L_E + NORM_QW;
    localparam int L_F1   = L_N + 1;
    localparam int L_F2   = L_F1 + 1;
    localparam int L_F3   = L_F2 + 1;
    localparam int L_G1   = L_F3 + 1;
    localparam int L_G2   = L_G1 + 1;
    localparam int L_H    = L_G2 + 1;
    localparam int L_DD   = L_H + DEPTH_QW;
    localparam int L_OUT  = L_DD + 1;
    localparam int PIPE_N = L_OUT + 1;
    localparam int R_DLY  = L_SQ - L_C2;
    localparam int CNT_W  = $clog2(PIPE_N + 1);
    localparam int DDEN_W = ZW_W + 1;
    localparam int DNUM_W = DDEN_W + DEPTH_QW;
    localparam int NNUM_W = WORD_W + 16;

    logic [DIM_W-1:0]         image_width_reg;
    logic [DIM_W-1:0]         image_height_reg;
    logic signed [WORD_W-1:0] region_min_x_reg;
    logic signed [WORD_W-1:0] region_max_x_reg;
    logic signed [WORD_W-1:0] region_min_y_reg;
    logic signed [WORD_W-1:0] region_max_y_reg;
    logic signed [WORD_W-1:0] coeff_reg [NUM_COEFFS];

    logic                     valid_reg [PIPE_N];
    side_t                    side_reg  [PIPE_N];
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;

    logic                     en;
    logic                     in_acc;
    logic                     pix_acc;
    logic                     load_acc;
    logic                     out_acc;
    logic                     cfg_wr;
    reg_index_t               cfg_idx;

    logic [PIX_W-1:0]         in_x;
    logic [PIX_W-1:0]         in_y;
    logic signed [WORD_W-1:0] in_t;
    logic                     in_fin;
    logic [CIDX_W-1:0]        in_cidx;
    logic signed [WORD_W-1:0] in_cval;
    logic [DIM_W-1:0]         wd_eff;
    logic [DIM_W-1:0]         ht_eff;
    logic [PIDX_W:0]          wy;

    logic [PIX_W-1:0]         x_reg;
    logic [PIX_W-1:0]         y_reg;
    logic [FRAC_QW-1:0]       fx_q;
    logic [FRAC_QW-1:0]       fy_q;
    logic signed [WORD_W:0]   dx;
    logic signed [WORD_W:0]   dy;
    logic signed [61:0]       prodx_reg;
    logic signed [61:0]       prody_reg;
    logic signed [WORD_W-1:0] sx_reg;
    logic signed [WORD_W-1:0] sy_reg;
    logic signed [63:0]       pu_reg [3];
    logic signed [63:0]       pv_reg [3];
    logic signed [WORD_W-1:0] r_reg  [3];
    logic signed [63:0]       sq_reg [3];
    logic [SUMSQ_W-1:0]       sum_reg;
    logic signed [WORD_W-1:0] r_dly_reg [R_DLY][3];
    logic [WORD_W-1:0]        len;
    logic [NNUM_W-1:0]        nnum_reg [3];
    logic [WORD_W-1:0]        nden_reg;
    logic [3:0]               nflag_reg;
    logic [3:0]               nflag_dly_reg [NORM_QW];
    logic [NORM_QW-1:0]       nq [3];
    logic signed [NORM_QW:0]  n_reg [3];
    logic signed [49:0]       pn_reg [3];
    logic signed [WORD_W-1:0] p_reg [3];
    logic signed [63:0]       mz_reg [3];
    logic signed [63:0]       mw_reg [3];
    logic signed [ZW_W-1:0]   z_reg;
    logic signed [ZW_W-1:0]   w_reg;
    logic                     wneg;
    logic signed [ZW_W:0]     za;
    logic signed [ZW_W:0]     wa;
    logic signed [ZW_W+1:0]   zsum;
    logic                     spec;
    logic                     spec_one;
    logic [DNUM_W-1:0]        dnum_reg;
    logic [DDEN_W-1:0]        dden_reg;
    logic [1:0]               dflag_reg;
    logic [1:0]               dflag_dly_reg [DEPTH_QW];
    logic [DEPTH_QW-1:0]      dq;
    logic [DDEN_W-1:0]        drem;
    logic [DDEN_W-1:0]        dden_out;
    logic                     round_up;
    logic [DEPTH_W-1:0]       depth_next;
    logic [DEPTH_W-1:0]       depth_reg;

    assign in_x    = s_axis_tdata[IN_X_LSB +: PIX_W];
    assign in_y    = s_axis_tdata[IN_Y_LSB +: PIX_W];
    assign in_t    = s_axis_tdata[IN_T_LSB +: WORD_W];
    assign in_fin  = s_axis_tdata[IN_FIN_BIT];
    assign in_cidx = s_axis_tdata[IN_CIDX_LSB +: CIDX_W];
    assign in_cval = s_axis_tdata[IN_CVAL_LSB +: WORD_W];

    assign en            = !valid_reg[L_OUT] || m_axis_tready;
    assign s_axis_tready = en && (s_axis_tuser[0] != FUNC_LOAD || cnt_reg == '0);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pix_acc       = in_acc && s_axis_tuser[0] != FUNC_LOAD;
    assign load_acc      = in_acc && s_axis_tuser[0] == FUNC_LOAD;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = valid_reg[L_OUT];
    assign m_axis_tdata  = {7'b0, side_reg[L_OUT].pidx, depth_reg};

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[4:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height_reg);
            REG_REGION_MIN_X: prdata = region_min_x_reg;
            REG_REGION_MAX_X: prdata = region_max_x_reg;
            REG_REGION_MIN_Y: prdata = region_min_y_reg;
            REG_REGION_MAX_Y: prdata = region_max_y_reg;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_W'(1);
            image_height_reg <= DIM_W'(1);
            region_min_x_reg <= '0;
            region_max_x_reg <= 32'sd65536;
            region_min_y_reg <= '0;
            region_max_y_reg <= 32'sd65536;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                REG_REGION_MIN_X: region_min_x_reg <= pwdata;
                REG_REGION_MAX_X: region_max_x_reg <= pwdata;
                REG_REGION_MIN_Y: region_min_y_reg <= pwdata;
                REG_REGION_MAX_Y: region_max_y_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_acc && int'(in_cidx) < NUM_COEFFS)
        begin
            coeff_reg[in_cidx[IDX_W-1:0]] <= in_cval;
        end
    end

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            wd_eff = DIM_W'(1);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            wd_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            wd_eff = image_width_reg;
        end
        if (image_height_reg == '0)
        begin
            ht_eff = DIM_W'(1);
        end
        else if (int'(image_height_reg) > MAX_HEIGHT)
        begin
            ht_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            ht_eff = image_height_reg;
        end
    end

    assign wy = (PIDX_W + 1)'(wd_eff) * (PIDX_W + 1)'(in_y);

    assign cnt_next = cnt_reg + CNT_W'(pix_acc) - CNT_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < PIPE_N; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (en)
            begin
                valid_reg[0] <= pix_acc;
                for (int i = 1; i < PIPE_N; i++)
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    rdtg_udiv #(.NUM_W(PIX_W + 16), .DEN_W(DIM_W), .Q_W(FRAC_QW)) u_frac_x (
        .clk(clk), .en(en), .num({x_reg, 16'b0}), .den(wd_eff),
        .quot(fx_q), .rem(), .den_out()
    );

    rdtg_udiv #(.NUM_W(PIX_W + 16), .DEN_W(DIM_W), .Q_W(FRAC_QW)) u_frac_y (
        .clk(clk), .en(en), .num({y_reg, 16'b0}), .den(ht_eff),
        .quot(fy_q), .rem(), .den_out()
    );

    assign dx = (WORD_W + 1)'(region_max_x_reg) - (WORD_W + 1)'(region_min_x_reg);
    assign dy = (WORD_W + 1)'(region_max_y_reg) - (WORD_W + 1)'(region_min_y_reg);

    rdtg_isqrt #(.IN_W(SUMSQ_W)) u_isqrt (
        .clk(clk), .en(en), .v(sum_reg), .root(len)
    );

    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_norm
            rdtg_udiv #(.NUM_W(NNUM_W), .DEN_W(WORD_W), .Q_W(NORM_QW)) u_norm (
                .clk(clk), .en(en), .num(nnum_reg[c]), .den(nden_reg),
                .quot(nq[c]), .rem(), .den_out()
            );
        end
    endgenerate

    rdtg_udiv #(.NUM_W(DNUM_W), .DEN_W(DDEN_W), .Q_W(DEPTH_QW)) u_depth (
        .clk(clk), .en(en), .num(dnum_reg), .den(dden_reg),
        .quot(dq), .rem(drem), .den_out(dden_out)
    );

    always_comb
    begin
        wneg     = w_reg[ZW_W-1];
        za       = wneg ? -(ZW_W + 1)'(z_reg) : (ZW_W + 1)'(z_reg);
        wa       = wneg ? -(ZW_W + 1)'(w_reg) : (ZW_W + 1)'(w_reg);
        zsum     = (ZW_W + 2)'(za) + (ZW_W + 2)'(wa);
        spec     = !side_reg[L_G2].fin || w_reg == '0 || zsum <= 0 || za >= wa;
        spec_one = !side_reg[L_G2].fin || w_reg == '0 || !(zsum <= 0);
    end

    assign round_up = {drem, 1'b0} >= {1'b0, dden_out};

    always_comb
    begin
        if (dflag_dly_reg[DEPTH_QW-1][0])
        begin
            depth_next = dflag_dly_reg[DEPTH_QW-1][1] ? DEPTH_ONE : '0;
        end
        else
        begin
            depth_next = DEPTH_W'(dq) + DEPTH_W'(round_up);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{fin: in_fin, t: in_t, pidx: wy[PIDX_W-1:0] + PIDX_W'(in_x)};
            for (int i = 1; i < PIPE_N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            x_reg <= in_x;
            y_reg <= in_y;

            prodx_reg <= dx * $signed({1'b0, fx_q});
            prody_reg <= dy * $signed({1'b0, fy_q});
            sx_reg    <= sat32(64'(region_min_x_reg) + rnd16(64'(prodx_reg)));
            sy_reg    <= sat32(64'(region_min_y_reg) + rnd16(64'(prody_reg)));

            for (int k = 0; k < 3; k++)
            begin
                pu_reg[k] <= sx_reg * coeff_reg[COEFF_DU + k];
                pv_reg[k] <= sy_reg * coeff_reg[COEFF_DV + k];
                r_reg[k]  <= sat32(64'(coeff_reg[COEFF_DIR00 + k]) + rnd16(pu_reg[k])
                                   + rnd16(pv_reg[k]));
                sq_reg[k] <= r_reg[k] * r_reg[k];
                r_dly_reg[0][k] <= r_reg[k];
                nnum_reg[k] <= {$unsigned(r_dly_reg[R_DLY-1][k][WORD_W-1] ?
                                          -r_dly_reg[R_DLY-1][k] : r_dly_reg[R_DLY-1][k]),
                                16'b0} + NNUM_W'(len >> 1);
                if (nflag_dly_reg[NORM_QW-1][3])
                begin
                    n_reg[k] <= '0;
                end
                else if (nflag_dly_reg[NORM_QW-1][k])
                begin
                    n_reg[k] <= -$signed({1'b0, nq[k]});
                end
                else
                begin
                    n_reg[k] <= $signed({1'b0, nq[k]});
                end
                pn_reg[k] <= n_reg[k] * side_reg[L_F1].t;
                p_reg[k]  <= sat32(64'(coeff_reg[COEFF_EYE + k]) + rnd16(64'(pn_reg[k])));
                mz_reg[k] <= coeff_reg[COEFF_ZROW + k] * p_reg[k];
                mw_reg[k] <= coeff_reg[COEFF_WROW + k] * p_reg[k];
            end
            sum_reg <= $unsigned(sq_reg[0]) + $unsigned(sq_reg[1]) + $unsigned(sq_reg[2]);
            for (int i = 1; i < R_DLY; i++)
            begin
                r_dly_reg[i] <= r_dly_reg[i-1];
            end

            nden_reg  <= (len == '0) ? WORD_W'(1) : len;
            nflag_reg <= {len == '0, r_dly_reg[R_DLY-1][2][WORD_W-1],
                          r_dly_reg[R_DLY-1][1][WORD_W-1], r_dly_reg[R_DLY-1][0][WORD_W-1]};
            nflag_dly_reg[0] <= nflag_reg;
            for (int i = 1; i < NORM_QW; i++)
            begin
                nflag_dly_reg[i] <= nflag_dly_reg[i-1];
            end

            z_reg <= ZW_W'(64'(coeff_reg[COEFF_ZROW + 3]) + rnd16(mz_reg[0])
                           + rnd16(mz_reg[1]) + rnd16(mz_reg[2]));
            w_reg <= ZW_W'(64'(coeff_reg[COEFF_WROW + 3]) + rnd16(mw_reg[0])
                           + rnd16(mw_reg[1]) + rnd16(mw_reg[2]));

            dnum_reg  <= spec ? '0 : {zsum[ZW_W:0], DEPTH_QW'(0)};
            dden_reg  <= spec ? DDEN_W'(1) : {wa[ZW_W-1:0], 1'b0};
            dflag_reg <= {spec_one, spec};
            dflag_dly_reg[0] <= dflag_reg;
            for (int i = 1; i < DEPTH_QW; i++)
            begin
                dflag_dly_reg[i] <= dflag_dly_reg[i-1];
            end

            depth_reg <= depth_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |-> cnt_reg == '0)
        else $error("Coefficient load accepted with pixels in flight.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cnt_reg != '0)
        else $error("Result offered with no pixel in flight.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[DEPTH_W-1:0] <= DEPTH_ONE)
        else $error("Depth above one.");

endmodule

>>> verif/tb.sv
module tb;
    import rdtg_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 130;
    localparam int LONG_HOLD    = 3000;
    localparam int N_SLOTS      = NUM_COEFFS_DEF;

    typedef struct {
        bit        func;
        bit [11:0] px;
        bit [11:0] py;
        bit [31:0] ray_dist;
        bit        fin;
        bit [4:0]  slot;
        bit [31:0] word;
    } pixel_item_t;

    typedef struct {
        bit [24:0] depth;
        bit [23:0] pidx;
    } depth_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // pixel_x, pixel_y, ray_distance, distance_finite, coeff_index, coeff_value
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    // func
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // depth, pixel_index
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    ray_distance_to_gl_depth_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 clk = ~clk;

    longint        coeff_tbl [N_SLOTS];
    bit [12:0]     cfg_width = 13'd1;
    bit [12:0]     cfg_height = 13'd1;
    longint        cfg_min_x = 0;
    longint        cfg_max_x = 65536;
    longint        cfg_min_y = 0;
    longint        cfg_max_y = 65536;
    depth_result_t depth_queue [$];
    int            failures = 0;
    int            cycle_count = 0;
    bit            no_gaps = 1'b0;
    bit            hold_request = 1'b0;
    int            stall_left = 0;

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint round_q16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint region_coord(longint lo, longint hi, int unsigned pos,
                                            int unsigned n);
        longint frac;
        frac = (longint'(pos) <<< 16) / longint'(n);
        return sat_word(lo + round_q16((hi - lo) * frac));
    endfunction

    function automatic bit [63:0] floor_sqrt(bit [63:0] v);
        bit [63:0] rem;
        bit [63:0] root;
        bit [63:0] b;
        rem = v;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint div_nearest(longint num, longint den);
        if (num >= 0)
        begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    function automatic bit [24:0] window_depth(longint z, longint w);
        bit [63:0] rem;
        bit [63:0] d;
        bit [63:0] q;
        if (w == 0)
        begin
            return DEPTH_ONE;
        end
        if (w < 0)
        begin
            z = -z;
            w = -w;
        end
        if (z + w <= 0)
        begin
            return '0;
        end
        if (z >= w)
        begin
            return DEPTH_ONE;
        end
        rem = z + w;
        d = w * 2;
        q = 0;
        for (int i = 0; i < 24; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                q = q | 64'd1;
            end
        end
        if (rem * 2 >= d)
        begin
            q = q + 1;
        end
        if (q > DEPTH_ONE)
        begin
            q = DEPTH_ONE;
        end
        return q[24:0];
    endfunction

    function automatic int unsigned eff_dim(bit [12:0] v, int unsigned max_v);
        if (v == 0)
        begin
            return 1;
        end
        return (v > max_v) ? max_v : v;
    endfunction

    task automatic apply_item(pixel_item_t it);
        depth_result_t res;
        int unsigned wd;
        int unsigned ht;
        longint sx;
        longint sy;
        longint t;
        longint z;
        longint w;
        longint dir [3];
        longint unit [3];
        longint pt [3];
        bit [63:0] sumsq;
        bit [63:0] len;
        if (it.func == FUNC_LOAD)
        begin
            if (it.slot < N_SLOTS)
            begin
                coeff_tbl[it.slot] = longint'(signed'(it.word));
            end
            return;
        end
        wd = eff_dim(cfg_width, MAX_WIDTH_DEF);
        ht = eff_dim(cfg_height, MAX_HEIGHT_DEF);
        res.pidx = 24'(longint'(it.px) + longint'(wd) * longint'(it.py));
        if (!it.fin)
        begin
            res.depth = DEPTH_ONE;
        end
        else
        begin
            t = longint'(signed'(it.ray_dist));
            sx = region_coord(cfg_min_x, cfg_max_x, it.px, wd);
            sy = region_coord(cfg_min_y, cfg_max_y, it.py, ht);
            sumsq = 0;
            for (int c = 0; c < 3; c++)
            begin
                dir[c] = sat_word(coeff_tbl[COEFF_DIR00 + c]
                                  + round_q16(sx * coeff_tbl[COEFF_DU + c])
                                  + round_q16(sy * coeff_tbl[COEFF_DV + c]));
                sumsq = sumsq + 64'(dir[c] * dir[c]);
            end
            len = floor_sqrt(sumsq);
            for (int c = 0; c < 3; c++)
            begin
                unit[c] = (len == 0) ? 0 : div_nearest(dir[c] * 65536, longint'(len));
                pt[c] = sat_word(coeff_tbl[COEFF_EYE + c] + round_q16(unit[c] * t));
            end
            z = coeff_tbl[COEFF_ZROW + 3];
            w = coeff_tbl[COEFF_WROW + 3];
            for (int c = 0; c < 3; c++)
            begin
                z = z + round_q16(coeff_tbl[COEFF_ZROW + c] * pt[c]);
                w = w + round_q16(coeff_tbl[COEFF_WROW + c] * pt[c]);
            end
            res.depth = window_depth(z, w);
        end
        depth_queue.push_back(res);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(pixel_item_t it);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.func;
        s_axis_tdata <= {2'b00, it.word, it.slot, it.fin, it.ray_dist, it.py, it.px};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        apply_item(it);
    endtask

    task automatic send_pixel(int x, int y, bit [31:0] ray_dist, bit fin);
        pixel_item_t it;
        it = '{func: 1'b0, px: 12'(x), py: 12'(y), ray_dist: ray_dist, fin: fin,
               slot: 5'($urandom), word: $urandom};
        send_item(it);
    endtask

    task automatic send_load(int slot, bit [31:0] word);
        pixel_item_t it;
        it = '{func: FUNC_LOAD, px: 12'($urandom), py: 12'($urandom), ray_dist: $urandom,
               fin: 1'($urandom), slot: 5'(slot), word: word};
        send_item(it);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (depth_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, bit [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width = value[12:0];
            REG_IMAGE_HEIGHT: cfg_height = value[12:0];
            REG_REGION_MIN_X: cfg_min_x = longint'(signed'(value));
            REG_REGION_MAX_X: cfg_max_x = longint'(signed'(value));
            REG_REGION_MIN_Y: cfg_min_y = longint'(signed'(value));
            REG_REGION_MAX_Y: cfg_max_y = longint'(signed'(value));
            default: ;
        endcase
    endtask

    task automatic set_config(bit [12:0] wd, bit [12:0] ht, bit [31:0] x0, bit [31:0] x1,
                              bit [31:0] y0, bit [31:0] y1);
        write_reg(REG_IMAGE_WIDTH, 32'(wd));
        write_reg(REG_IMAGE_HEIGHT, 32'(ht));
        write_reg(REG_REGION_MIN_X, x0);
        write_reg(REG_REGION_MAX_X, x1);
        write_reg(REG_REGION_MIN_Y, y0);
        write_reg(REG_REGION_MAX_Y, y1);
    endtask

    function automatic bit [31:0] jitter(int base, int span);
        return base + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // A perspective camera looking down -z with near 1 and far 100, slightly disturbed.
    task automatic load_camera(int span, bit shuffled);
        bit [31:0] words [N_SLOTS];
        int order [N_SLOTS];
        int k;
        int tmp;
        words = '{jitter(0, 4 * 65536), jitter(0, 4 * 65536), jitter(0, 4 * 65536),
                  jitter(-65536, span), jitter(-65536, span), jitter(-65536, span),
                  jitter(131072, span), jitter(0, span), jitter(0, span),
                  jitter(0, span), jitter(131072, span), jitter(0, span),
                  jitter(0, span), jitter(0, span), jitter(-66860, span),
                  jitter(-132392, span), jitter(0, span), jitter(0, span),
                  jitter(-65536, span), jitter(0, span)};
        for (int i = 0; i < N_SLOTS; i++)
        begin
            order[i] = i;
        end
        if (shuffled)
        begin
            for (int i = N_SLOTS - 1; i > 0; i--)
            begin
                k = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[k];
                order[k] = tmp;
            end
        end
        for (int i = 0; i < N_SLOTS; i++)
        begin
            send_load(order[i], words[order[i]]);
        end
    endtask

    task automatic random_pixel(int wd, int ht);
        int x;
        int y;
        bit [31:0] ray_dist;
        x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, wd - 1);
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, ht - 1);
        ray_dist = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(65536, 100 * 65536);
        send_pixel(x, y, ray_dist, $urandom_range(0, 9) != 0);
    endtask

    task automatic test_directed();
        load_camera(0, 1'b0);
        send_load(20, 32'hdead_beef);
        send_load(31, 32'hffff_ffff);
        send_pixel(0, 0, 32'h000a_0000, 1'b1);
        send_pixel(0, 0, 32'h000a_0000, 1'b0);
        send_pixel(4095, 4095, 32'h0032_0000, 1'b1);
        send_pixel(0, 0, 32'h0000_0000, 1'b1);
        send_pixel(0, 0, 32'h7fff_ffff, 1'b1);
        send_pixel(0, 0, 32'h8000_0000, 1'b1);
        send_pixel(4095, 0, 32'hffff_ffff, 1'b0);
        // A direction of zero length leaves the world point at the eye.
        for (int c = 0; c < 9; c++)
        begin
            send_load(COEFF_DIR00 + c, 32'h0);
        end
        send_pixel(0, 0, 32'h0005_0000, 1'b1);
        load_camera(0, 1'b0);
        // A w row of zero forces depth to one.
        for (int c = 0; c < 4; c++)
        begin
            send_load(COEFF_WROW + c, 32'h0);
        end
        send_pixel(0, 0, 32'h0005_0000, 1'b1);
        load_camera(0, 1'b0);
        wait_drain();
    endtask

    task automatic test_config_extremes();
        set_config(13'd0, 13'd0, 32'h0, 32'h1_0000, 32'h0, 32'h1_0000);
        send_pixel(3, 2, 32'h0008_0000, 1'b1);
        send_pixel(4095, 4095, 32'h0008_0000, 1'b0);
        wait_drain();
        set_config(13'h1fff, 13'h1000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h8000_0000);
        for (int i = 0; i < 8; i++)
        begin
            random_pixel(4096, 4096);
        end
        send_pixel(4095, 4095, 32'h0008_0000, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_frames();
        int wd;
        int ht;
        for (int ph = 0; ph < 6; ph++)
        begin
            wd = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
            ht = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
            set_config(13'(wd), 13'(ht), jitter(-65536, 8192), jitter(65536, 8192),
                       jitter(-65536, 8192), jitter(65536, 8192));
            for (int f = 0; f < 4; f++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    for (int i = 0; i < N_SLOTS; i++)
                    begin
                        send_load(i, $urandom);
                    end
                end
                else
                begin
                    load_camera($urandom_range(0, 4000), 1'b1);
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    send_load($urandom_range(N_SLOTS, 31), $urandom);
                end
                for (int i = 0; i < 27; i++)
                begin
                    random_pixel(wd, ht);
                end
            end
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        set_config(13'd40, 13'd30, 32'hffff_0000, 32'h0001_0000, 32'hffff_0000,
                   32'h0001_0000);
        load_camera(1000, 1'b1);
        wait_drain();
        hold_request = 1'b1;
        no_gaps = 1'b1;
        for (int i = 0; i < 300; i++)
        begin
            random_pixel(40, 30);
        end
        no_gaps = 1'b0;
        wait_drain();
        for (int i = 0; i < 100; i++)
        begin
            random_pixel(40, 30);
        end
        wait_drain();
    endtask

    always @(posedge clk)
    begin
        int r;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                m_axis_tready <= (r < 70);
                if (r >= 95)
                begin
                    stall_left = $urandom_range(10, 40);
                end
                else if (r >= 70)
                begin
                    stall_left = $urandom_range(0, 2);
                end
            end
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        failures++;
    endtask

    always @(posedge clk)
    begin
        depth_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (depth_queue.size() == 0)
            begin
                report_mismatch("unexpected transaction", m_axis_tdata, 0);
            end
            else
            begin
                want = depth_queue.pop_front();
                if (m_axis_tdata[24:0] != want.depth)
                begin
                    report_mismatch("depth", m_axis_tdata[24:0], want.depth);
                end
                if (m_axis_tdata[48:25] != want.pidx)
                begin
                    report_mismatch("pixel_index", m_axis_tdata[48:25], want.pidx);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < N_SLOTS; i++)
        begin
            coeff_tbl[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_frames();
        wait_drain();
        if (depth_queue.size() != 0)
        begin
            failures++;
        end
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> ray_distance_to_gl_depth_core.f
design/rdtg_pkg.sv
design/rdtg_udiv.sv
design/rdtg_isqrt.sv
design/ray_distance_to_gl_depth_core.sv
verif/tb.sv
